// ----- rtl/core/pwfe_pkg.sv -----
// Package for the plane wave field evaluator: payload and coefficient types,
// configuration register codes, the shared CORDIC step and rounding helpers.
// No dependencies.
package pwfe_pkg;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int CW   = 34;
    localparam int FW   = 30;
    localparam int AMPW = 27;
    localparam int DFW  = 27;
    localparam int K0TW = 50;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER_TURN    = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN       = 34'sd2147483648;
    localparam logic [29:0]          TURNS_PER_RAD_Q32 = 30'd683565276;

    typedef enum logic [2:0] {
        KIND_E   = 3'd0,
        KIND_H   = 3'd1,
        KIND_DEX = 3'd2,
        KIND_DEY = 3'd3,
        KIND_DEZ = 3'd4,
        KIND_DHX = 3'd5,
        KIND_DHY = 3'd6,
        KIND_DHZ = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        CFG_AMPLITUDE    = 3'd0,
        CFG_WAVENUMBER   = 3'd1,
        CFG_POLAR        = 3'd2,
        CFG_AZIMUTH      = 3'd3,
        CFG_POLARIZATION = 3'd4,
        CFG_INV_IMP      = 3'd5
    } t_cfg_index;

    typedef enum logic [2:0] {
        CF_IDLE,
        CF_LOAD,
        CF_ITER,
        CF_STORE,
        CF_PROD1,
        CF_PROD2,
        CF_PROD3
    } t_coeff_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x_re;
        logic signed [31:0] out_x_im;
        logic signed [31:0] out_y_re;
        logic signed [31:0] out_y_im;
        logic signed [31:0] out_z_re;
        logic signed [31:0] out_z_im;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [23:0] amplitude;
        logic [23:0] wavenumber;
        logic [15:0] polar_angle;
        logic [15:0] azimuth_angle;
        logic [15:0] polarization_angle;
        logic [23:0] inv_impedance;
    } t_cfg;

    typedef struct packed {
        logic [2:0][23:0]   dir;
        logic [2:0][AMPW-1:0] amp;
        logic [2:0][DFW-1:0]  dfac;
        logic [K0TW-1:0]    k0t;
    } t_coeffs;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } t_cordic;

    function automatic logic signed [CW-1:0] atan_turn(logic [4:0] idx);
        logic signed [CW-1:0] a;
        case (idx)
            5'd0:  a = 34'sd536870912;
            5'd1:  a = 34'sd316933406;
            5'd2:  a = 34'sd167458907;
            5'd3:  a = 34'sd85004756;
            5'd4:  a = 34'sd42667331;
            5'd5:  a = 34'sd21354465;
            5'd6:  a = 34'sd10679838;
            5'd7:  a = 34'sd5340245;
            5'd8:  a = 34'sd2670163;
            5'd9:  a = 34'sd1335087;
            5'd10: a = 34'sd667544;
            5'd11: a = 34'sd333772;
            5'd12: a = 34'sd166886;
            5'd13: a = 34'sd83443;
            5'd14: a = 34'sd41722;
            5'd15: a = 34'sd20861;
            5'd16: a = 34'sd10430;
            5'd17: a = 34'sd5215;
            5'd18: a = 34'sd2608;
            5'd19: a = 34'sd1304;
            5'd20: a = 34'sd652;
            5'd21: a = 34'sd326;
            5'd22: a = 34'sd163;
            5'd23: a = 34'sd81;
            5'd24: a = 34'sd41;
            5'd25: a = 34'sd20;
            5'd26: a = 34'sd10;
            5'd27: a = 34'sd5;
            5'd28: a = 34'sd3;
            5'd29: a = 34'sd1;
            5'd30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

    // Folds the angle into the right half plane and loads the gain.
    function automatic t_cordic cordic_init(logic [31:0] turn);
        t_cordic v;
        logic signed [CW-1:0] z;
        z = 34'($signed(turn));
        v.x = CORDIC_GAIN_Q30;
        v.y = '0;
        v.z = z;
        v.flip = 1'b0;
        if (z > QUARTER_TURN) begin
            v.z = z - HALF_TURN;
            v.flip = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            v.z = z + HALF_TURN;
            v.flip = 1'b1;
        end
        return v;
    endfunction

    function automatic t_cordic cordic_step(t_cordic v, logic [4:0] idx);
        t_cordic n;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = v.x >>> idx;
        ys = v.y >>> idx;
        n.flip = v.flip;
        if (!v.z[CW-1]) begin
            n.x = v.x - ys;
            n.y = v.y + xs;
            n.z = v.z - atan_turn(idx);
        end else begin
            n.x = v.x + ys;
            n.y = v.y - xs;
            n.z = v.z + atan_turn(idx);
        end
        return n;
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [63:0] rnd_s(logic signed [63:0] v, logic [5:0] sh);
        logic signed [63:0] half;
        half = 64'sd1 <<< (sh - 6'd1);
        return (v + half) >>> sh;
    endfunction

endpackage

// ----- rtl/core/pwfe_cordic_pipe.sv -----
// Unrolled CORDIC rotator, one register stage per iteration plus a fold stage.
// Depends on pwfe_pkg.
module pwfe_cordic_pipe #(
    parameter int STAGES = pwfe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [31:0]                    i_turn,
    input  logic [2:0]                     i_kind,
    output logic                           o_valid,
    output logic [2:0]                     o_kind,
    output logic signed [pwfe_pkg::CW-1:0] o_cos,
    output logic signed [pwfe_pkg::CW-1:0] o_sin
);
    import pwfe_pkg::*;

    t_cordic    r_st   [STAGES+1];
    logic [2:0] r_kind [STAGES+1];
    logic [STAGES:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[STAGES-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0]   <= cordic_init(i_turn);
        r_kind[0] <= i_kind;
        for (int g = 0; g < STAGES; g++) begin
            r_st[g+1]   <= cordic_step(r_st[g], 5'(g));
            r_kind[g+1] <= r_kind[g];
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_kind  = r_kind[STAGES];
    assign o_cos   = r_st[STAGES].flip ? -r_st[STAGES].x : r_st[STAGES].x;
    assign o_sin   = r_st[STAGES].flip ? -r_st[STAGES].y : r_st[STAGES].y;

endmodule

// ----- rtl/core/pwfe_coeff.sv -----
// Coefficient sequencer: derives direction, polarisation, amplitude, derivative factors
// and the phase scale k0t from the configuration with one iterative CORDIC. Depends on pwfe_pkg.
module pwfe_coeff #(
    parameter int STAGES = pwfe_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_refresh,
    input  pwfe_pkg::t_cfg    i_cfg,
    output pwfe_pkg::t_coeffs o_coeffs,
    output logic              o_busy
);
    import pwfe_pkg::*;

    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam logic [IW-1:0] ITER_LAST = IW'(STAGES - 1);

    t_coeff_state r_state, n_state;
    logic [IW-1:0] r_iter;
    logic [1:0]    r_sel;
    t_cordic       r_cv;
    logic signed [23:0] r_cq [3];
    logic signed [23:0] r_sq [3];
    logic signed [23:0] r_t0, r_t1, r_u0, r_u1;
    logic [2:0][23:0]     r_dir;
    logic [2:0][23:0]     r_pol;
    logic [2:0][AMPW-1:0] r_amp;
    logic [2:0][DFW-1:0]  r_dfac;
    logic [K0TW-1:0]      r_k0t;

    logic do_load, do_iter, do_store, do_p1, do_p2, do_p3;
    logic [15:0] angle;
    logic signed [CW-1:0] cfin, sfin;
    logic signed [63:0] rc, rs;
    logic signed [63:0] m_d0, m_d1, m_t0, m_t1, m_u0, m_u1, m_p2;
    logic signed [63:0] m_p0, m_p1;
    logic signed [63:0] m_f [3];
    logic signed [63:0] m_a [3];
    logic [53:0] k0_prod;
    logic signed [23:0] ct, st, cp, sp, ca, sa;

    always_comb begin
        n_state = r_state;
        if (i_refresh) begin
            n_state = CF_LOAD;
        end else begin
            case (r_state)
                CF_IDLE:  n_state = CF_IDLE;
                CF_LOAD:  n_state = CF_ITER;
                CF_ITER:  n_state = (r_iter == ITER_LAST) ? CF_STORE : CF_ITER;
                CF_STORE: n_state = (r_sel == 2'd2) ? CF_PROD1 : CF_LOAD;
                CF_PROD1: n_state = CF_PROD2;
                CF_PROD2: n_state = CF_PROD3;
                CF_PROD3: n_state = CF_IDLE;
                default:  n_state = CF_IDLE;
            endcase
        end
    end

    always_comb begin
        do_load  = 1'b0;
        do_iter  = 1'b0;
        do_store = 1'b0;
        do_p1    = 1'b0;
        do_p2    = 1'b0;
        do_p3    = 1'b0;
        o_busy   = 1'b1;
        case (r_state)
            CF_IDLE:  o_busy   = 1'b0;
            CF_LOAD:  do_load  = 1'b1;
            CF_ITER:  do_iter  = 1'b1;
            CF_STORE: do_store = 1'b1;
            CF_PROD1: do_p1    = 1'b1;
            CF_PROD2: do_p2    = 1'b1;
            CF_PROD3: do_p3    = 1'b1;
            default:  o_busy   = 1'b0;
        endcase
    end

    always_comb begin
        case (r_sel)
            2'd0:    angle = i_cfg.polar_angle;
            2'd1:    angle = i_cfg.azimuth_angle;
            default: angle = i_cfg.polarization_angle;
        endcase
        ct = r_cq[0];
        st = r_sq[0];
        cp = r_cq[1];
        sp = r_sq[1];
        ca = r_cq[2];
        sa = r_sq[2];
        cfin = r_cv.flip ? -r_cv.x : r_cv.x;
        sfin = r_cv.flip ? -r_cv.y : r_cv.y;
        rc = rnd_s(64'(cfin), 6'd8);
        rs = rnd_s(64'(sfin), 6'd8);
        m_d0 = rnd_s(64'(st * cp), 6'd22);
        m_d1 = rnd_s(64'(st * sp), 6'd22);
        m_t0 = rnd_s(64'(ca * cp), 6'd22);
        m_t1 = rnd_s(64'(ca * sp), 6'd22);
        m_u0 = rnd_s(64'(sa * sp), 6'd22);
        m_u1 = rnd_s(64'(sa * cp), 6'd22);
        m_p2 = -rnd_s(64'(ca * st), 6'd22);
        k0_prod = 54'(i_cfg.wavenumber * TURNS_PER_RAD_Q32) + 54'd8;
        m_p0 = rnd_s(64'(r_t0 * ct), 6'd22) - 64'(r_u0);
        m_p1 = rnd_s(64'(r_t1 * ct), 6'd22) + 64'(r_u1);
        for (int i = 0; i < 3; i++) begin
            m_f[i] = rnd_s(64'($signed({1'b0, i_cfg.wavenumber}) * $signed(r_dir[i])),
                           6'd22);
            m_a[i] = rnd_s(64'($signed(r_pol[i]) * $signed({1'b0, i_cfg.amplitude})),
                           6'd22);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CF_IDLE;
            r_iter  <= '0;
            r_sel   <= '0;
            r_dir   <= '0;
            r_pol   <= '0;
            r_amp   <= '0;
            r_dfac  <= '0;
            r_k0t   <= '0;
        end else begin
            r_state <= n_state;
            if (i_refresh) begin
                r_sel <= '0;
            end else if (do_store) begin
                r_sel <= r_sel + 2'd1;
            end
            if (do_load) begin
                r_iter <= '0;
            end else if (do_iter) begin
                r_iter <= r_iter + IW'(1);
            end
            if (do_p1) begin
                r_dir[0] <= m_d0[23:0];
                r_dir[1] <= m_d1[23:0];
                r_dir[2] <= ct;
                r_pol[2] <= m_p2[23:0];
                r_k0t    <= k0_prod[53:4];
            end
            if (do_p2) begin
                r_pol[0] <= m_p0[23:0];
                r_pol[1] <= m_p1[23:0];
                for (int i = 0; i < 3; i++) begin
                    r_dfac[i] <= m_f[i][DFW-1:0];
                end
            end
            if (do_p3) begin
                for (int i = 0; i < 3; i++) begin
                    r_amp[i] <= m_a[i][AMPW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_cv <= cordic_init({angle, 16'd0});
        end else if (do_iter) begin
            r_cv <= cordic_step(r_cv, 5'(r_iter));
        end
        if (do_store) begin
            r_cq[r_sel] <= rc[23:0];
            r_sq[r_sel] <= rs[23:0];
        end
        if (do_p1) begin
            r_t0 <= m_t0[23:0];
            r_t1 <= m_t1[23:0];
            r_u0 <= m_u0[23:0];
            r_u1 <= m_u1[23:0];
        end
    end

    assign o_coeffs.dir  = r_dir;
    assign o_coeffs.amp  = r_amp;
    assign o_coeffs.dfac = r_dfac;
    assign o_coeffs.k0t  = r_k0t;

endmodule

// ----- rtl/core/pwfe_phase.sv -----
// Phase pipeline: projection of the point on the direction and scaling by the
// wavenumber into a 32-bit turn fraction, four register stages. Depends on pwfe_pkg.
module pwfe_phase (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pwfe_pkg::t_in_item i_item,
    input  pwfe_pkg::t_coeffs  i_coeffs,
    output logic               o_valid,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_turn
);
    import pwfe_pkg::*;

    logic [3:0] r_v;
    logic signed [55:0] r_prod [3];
    logic signed [35:0] r_dq;
    logic signed [61:0] r_pl, r_ph;
    logic [31:0] r_turn;
    logic [2:0]  r_kind1, r_kind2, r_kind3, r_kind4;

    logic signed [31:0] pos [3];
    logic signed [57:0] dot;
    logic signed [63:0] dq;
    logic [63:0] sum;

    always_comb begin
        pos[0] = i_item.pos_x;
        pos[1] = i_item.pos_y;
        pos[2] = i_item.pos_z;
        dot = 58'(r_prod[0]) + 58'(r_prod[1]) + 58'(r_prod[2]);
        dq  = rnd_s(64'(dot), 6'd22);
        sum = {r_ph[38:0], 25'd0} + 64'(r_pl) + 64'h0000_0000_8000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= 56'($signed(i_coeffs.dir[i]) * pos[i]);
        end
        r_kind1 <= i_item.kind;
        r_dq    <= dq[35:0];
        r_kind2 <= r_kind1;
        r_pl    <= 62'($signed({1'b0, i_coeffs.k0t[24:0]}) * r_dq);
        r_ph    <= 62'($signed({1'b0, i_coeffs.k0t[K0TW-1:25]}) * r_dq);
        r_kind3 <= r_kind2;
        r_turn  <= sum[63:32];
        r_kind4 <= r_kind3;
    end

    assign o_valid = r_v[3];
    assign o_kind  = r_kind4;
    assign o_turn  = r_turn;

endmodule

// ----- rtl/core/pwfe_field.sv -----
// Field pipeline: electric field from cos and sin, magnetic field by the cross
// product, derivative factor and saturation, four register stages. Depends on pwfe_pkg.
module pwfe_field (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [2:0]                     i_kind,
    input  logic signed [pwfe_pkg::CW-1:0] i_cos,
    input  logic signed [pwfe_pkg::CW-1:0] i_sin,
    input  pwfe_pkg::t_coeffs              i_coeffs,
    input  logic [23:0]                    i_inv_impedance,
    output logic                           o_valid,
    output pwfe_pkg::t_out_item            o_result
);
    import pwfe_pkg::*;

    function automatic logic signed [31:0] sat32(logic signed [63:0] v, output logic clip);
        clip = 1'b0;
        if (v > 64'sd2147483647) begin
            clip = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            clip = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    logic [3:0] r_v;
    logic [2:0] r_kind1, r_kind2, r_kind3;
    logic signed [FW-1:0] r_fre [3];
    logic signed [FW-1:0] r_fim [3];
    logic signed [FW-1:0] r_fre2 [3];
    logic signed [FW-1:0] r_fim2 [3];
    logic signed [FW-1:0] r_cr [3];
    logic signed [FW-1:0] r_ci [3];
    logic signed [FW-1:0] r_gre [3];
    logic signed [FW-1:0] r_gim [3];
    t_out_item r_out;

    logic signed [63:0] e_re [3];
    logic signed [63:0] e_im [3];
    logic signed [63:0] x_re [3];
    logic signed [63:0] x_im [3];
    logic signed [63:0] h_re [3];
    logic signed [63:0] h_im [3];
    logic signed [63:0] d_re [3];
    logic signed [63:0] d_im [3];
    logic signed [31:0] res [6];
    logic [5:0] clip;
    logic signed [23:0] ka, kb;
    logic signed [DFW-1:0] f;
    logic is_h, is_deriv;
    t_kind kind3;
    t_out_item n_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e_re[i] = rnd_s(64'($signed(i_coeffs.amp[i]) * i_cos), 6'd30);
            e_im[i] = rnd_s(64'($signed(i_coeffs.amp[i]) * i_sin), 6'd30);
        end
        for (int i = 0; i < 3; i++) begin
            ka = $signed(i_coeffs.dir[(i == 2) ? 0 : i + 1]);
            kb = $signed(i_coeffs.dir[(i == 0) ? 2 : i - 1]);
            x_re[i] = rnd_s(64'(ka * r_fre[(i == 0) ? 2 : i - 1])
                          - 64'(kb * r_fre[(i == 2) ? 0 : i + 1]), 6'd22);
            x_im[i] = rnd_s(64'(ka * r_fim[(i == 0) ? 2 : i - 1])
                          - 64'(kb * r_fim[(i == 2) ? 0 : i + 1]), 6'd22);
            h_re[i] = rnd_s(-64'(r_cr[i] * $signed({1'b0, i_inv_impedance})), 6'd24);
            h_im[i] = rnd_s(-64'(r_ci[i] * $signed({1'b0, i_inv_impedance})), 6'd24);
        end
        is_h = r_kind2 inside {KIND_H, KIND_DHX, KIND_DHY, KIND_DHZ};
        kind3 = t_kind'(r_kind3);
        is_deriv = !(kind3 inside {KIND_E, KIND_H});
        case (kind3)
            KIND_DEX, KIND_DHX: f = $signed(i_coeffs.dfac[0]);
            KIND_DEY, KIND_DHY: f = $signed(i_coeffs.dfac[1]);
            KIND_DEZ, KIND_DHZ: f = $signed(i_coeffs.dfac[2]);
            default:            f = '0;
        endcase
        for (int i = 0; i < 3; i++) begin
            if (is_deriv) begin
                d_re[i] = rnd_s(-64'(r_gim[i] * f), 6'd20);
                d_im[i] = rnd_s(64'(r_gre[i] * f), 6'd20);
            end else begin
                d_re[i] = 64'(r_gre[i]);
                d_im[i] = 64'(r_gim[i]);
            end
            res[2*i]   = sat32(d_re[i], clip[2*i]);
            res[2*i+1] = sat32(d_im[i], clip[2*i+1]);
        end
        n_out.out_x_re  = res[0];
        n_out.out_x_im  = res[1];
        n_out.out_y_re  = res[2];
        n_out.out_y_im  = res[3];
        n_out.out_z_re  = res[4];
        n_out.out_z_im  = res[5];
        n_out.saturated = |clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind1 <= i_kind;
        r_kind2 <= r_kind1;
        r_kind3 <= r_kind2;
        for (int i = 0; i < 3; i++) begin
            r_fre[i]  <= e_re[i][FW-1:0];
            r_fim[i]  <= e_im[i][FW-1:0];
            r_fre2[i] <= r_fre[i];
            r_fim2[i] <= r_fim[i];
            r_cr[i]   <= x_re[i][FW-1:0];
            r_ci[i]   <= x_im[i][FW-1:0];
            r_gre[i]  <= is_h ? h_re[i][FW-1:0] : r_fre2[i];
            r_gim[i]  <= is_h ? h_im[i][FW-1:0] : r_fim2[i];
        end
        r_out <= n_out;
    end

    assign o_valid  = r_v[3];
    assign o_result = r_out;

endmodule

// ----- rtl/core/plane_wave_field_evaluator.sv -----
// Plane wave field evaluator, top level: configuration registers, coefficient
// sequencer and the phase, CORDIC and field pipelines. Depends on pwfe_pkg.
// Takes one transaction per clock while busy is low; its result is strobed once it has passed
// the four phase, fold plus CORDIC and four field stages.
// A register write holds busy high while the coefficients are refreshed.
// Reset restores register defaults, clears coefficients to zero and empties the pipeline.
module plane_wave_field_evaluator #(
    parameter int CORDIC_STAGES = pwfe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pwfe_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output pwfe_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);
    import pwfe_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic refresh;
    t_coeffs coeffs;
    logic ph_valid, cd_valid;
    logic [2:0] ph_kind, cd_kind;
    logic [31:0] ph_turn;
    logic signed [CW-1:0] cd_cos, cd_sin;

    always_comb begin
        n_cfg   = r_cfg;
        refresh = 1'b0;
        if (i_cfg_we) begin
            refresh = 1'b1;
            case (i_cfg_index)
                CFG_AMPLITUDE:    n_cfg.amplitude          = i_cfg_data;
                CFG_WAVENUMBER:   n_cfg.wavenumber         = i_cfg_data;
                CFG_POLAR:        n_cfg.polar_angle        = i_cfg_data[15:0];
                CFG_AZIMUTH:      n_cfg.azimuth_angle      = i_cfg_data[15:0];
                CFG_POLARIZATION: n_cfg.polarization_angle = i_cfg_data[15:0];
                CFG_INV_IMP:      n_cfg.inv_impedance      = i_cfg_data;
                default:          refresh = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amplitude          <= 24'd65536;
            r_cfg.wavenumber         <= 24'd1048576;
            r_cfg.polar_angle        <= '0;
            r_cfg.azimuth_angle      <= '0;
            r_cfg.polarization_angle <= '0;
            r_cfg.inv_impedance      <= 24'd44534;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pwfe_coeff #(
        .STAGES (CORDIC_STAGES)
    ) u_coeff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_refresh (refresh),
        .i_cfg     (r_cfg),
        .o_coeffs  (coeffs),
        .o_busy    (busy)
    );

    pwfe_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_item   (i_item),
        .i_coeffs (coeffs),
        .o_valid  (ph_valid),
        .o_kind   (ph_kind),
        .o_turn   (ph_turn)
    );

    pwfe_cordic_pipe #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_valid),
        .i_turn  (ph_turn),
        .i_kind  (ph_kind),
        .o_valid (cd_valid),
        .o_kind  (cd_kind),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    pwfe_field u_field (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (cd_valid),
        .i_kind          (cd_kind),
        .i_cos           (cd_cos),
        .i_sin           (cd_sin),
        .i_coeffs        (coeffs),
        .i_inv_impedance (r_cfg.inv_impedance),
        .o_valid         (o_strobe),
        .o_result        (o_result)
    );

endmodule
